[rtl/tbef_pkg.sv]
package tbef_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // rest length and stiffness registers are unsigned Q15.16, 31 bits
  localparam int REG_W     = 31;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_AXES  = 2;

  localparam logic [REG_W-1:0] REST_RESET  = REG_W'(65536);
  localparam logic [REG_W-1:0] STIFF_RESET = REG_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REST  = 2'd0,
    CFG_STIFF = 2'd1,
    CFG_SLACK = 2'd2
  } cfg_reg_e;

endpackage

[rtl/tbef_if.sv]
interface tbef_in_if #(parameter int CW = 32);
  logic              valid;
  logic              ready;
  logic signed [CW-1:0] first_x;
  logic signed [CW-1:0] first_y;
  logic signed [CW-1:0] second_x;
  logic signed [CW-1:0] second_y;

  modport source (output valid, first_x, first_y, second_x, second_y, input ready);
  modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

interface tbef_out_if #(parameter int CW = 32);
  logic              valid;
  logic              ready;
  logic signed [CW-1:0] force_first_x;
  logic signed [CW-1:0] force_first_y;
  logic signed [CW-1:0] force_second_x;
  logic signed [CW-1:0] force_second_y;

  modport source (output valid, force_first_x, force_first_y, force_second_x,
                  force_second_y, input ready);
  modport sink   (input valid, force_first_x, force_first_y, force_second_x,
                  force_second_y, output ready);
endinterface

[rtl/tbef_sqrt_pipe.sv]
module tbef_sqrt_pipe #(
  parameter int LW  = 33,
  parameter int SBW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*LW-1:0]   rad_i,
  input  logic [SBW-1:0]    sb_i,
  output logic              valid_o,
  output logic [LW-1:0]     root_o,
  output logic [SBW-1:0]    sb_o
);
  // one root bit per stage, restoring square root
  localparam int RMW = LW + 2;

  logic            v_q    [LW];
  logic [RMW-1:0]  rem_q  [LW];
  logic [LW-1:0]   root_q [LW];
  logic [SBW-1:0]  sb_q   [LW];
  logic [2*LW-1:0] rad_q  [LW-1];

  logic [RMW-1:0]  rem_d  [LW];
  logic [LW-1:0]   root_d [LW];
  logic [2*LW-1:0] rad_d  [LW];

  for (genvar k = 0; k < LW; k++) begin : g_stage
    logic [RMW-1:0]  rem_in, cur, trial;
    logic [LW-1:0]   root_in;
    logic [2*LW-1:0] rad_in;
    logic            fit;
    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end
    assign cur       = {rem_in[RMW-3:0], rad_in[2*LW-1 -: 2]};
    assign trial     = {root_in, 2'b01};
    assign fit       = (cur >= trial);
    assign rem_d[k]  = fit ? (cur - trial) : cur;
    assign root_d[k] = {root_in[LW-2:0], fit};
    assign rad_d[k]  = {rad_in[2*LW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LW; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < LW; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb_q[0] <= sb_i;
      for (int k = 1; k < LW; k++) sb_q[k] <= sb_q[k-1];
      for (int k = 0; k < LW; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
      end
      for (int k = 0; k < LW - 1; k++) rad_q[k] <= rad_d[k];
    end
  end

  assign valid_o = v_q[LW-1];
  assign root_o  = root_q[LW-1];
  assign sb_o    = sb_q[LW-1];

endmodule

[rtl/tbef_div_pipe.sv]
module tbef_div_pipe #(
  parameter int LW  = 33,
  parameter int QW  = 48,
  parameter int SBW = 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [LW-1:0]                        div_i,
  input  logic [tbef_pkg::NUM_AXES-1:0][LW-1:0] num_hi_i,
  input  logic [tbef_pkg::NUM_AXES-1:0][QW-1:0] num_lo_i,
  input  logic [SBW-1:0]                       sb_i,
  output logic                                 valid_o,
  output logic [tbef_pkg::NUM_AXES-1:0][QW-1:0] quot_o,
  output logic [SBW-1:0]                       sb_o
);
  import tbef_pkg::*;

  // one quotient bit per stage; the low word shifts out numerator bits
  // and takes quotient bits in. num_hi must be below the divisor.
  logic                           v_q   [QW];
  logic [NUM_AXES-1:0][QW-1:0]    lo_q  [QW];
  logic [SBW-1:0]                 sb_q  [QW];
  logic [NUM_AXES-1:0][LW-1:0]    rem_q [QW-1];
  logic [LW-1:0]                  d_q   [QW-1];

  logic [NUM_AXES-1:0][QW-1:0]    lo_d  [QW];
  logic [NUM_AXES-1:0][LW-1:0]    rem_d [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NUM_AXES-1:0][LW-1:0] rem_in;
    logic [NUM_AXES-1:0][QW-1:0] lo_in;
    logic [LW-1:0]               d_in;
    if (k == 0) begin : g_first
      assign rem_in = num_hi_i;
      assign lo_in  = num_lo_i;
      assign d_in   = div_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign d_in   = d_q[k-1];
    end
    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      logic [LW:0] cur, diff;
      logic        fit;
      assign cur          = {rem_in[a], lo_in[a][QW-1]};
      assign diff         = cur - {1'b0, d_in};
      assign fit          = (cur >= {1'b0, d_in});
      assign rem_d[k][a]  = fit ? diff[LW-1:0] : cur[LW-1:0];
      assign lo_d[k][a]   = {lo_in[a][QW-2:0], fit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < QW; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < QW; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb_q[0] <= sb_i;
      d_q[0]  <= div_i;
      for (int k = 1; k < QW; k++) sb_q[k] <= sb_q[k-1];
      for (int k = 1; k < QW - 1; k++) d_q[k] <= d_q[k-1];
      for (int k = 0; k < QW; k++) lo_q[k] <= lo_d[k];
      for (int k = 0; k < QW - 1; k++) rem_q[k] <= rem_d[k];
    end
  end

  assign valid_o = v_q[QW-1];
  assign quot_o  = lo_q[QW-1];
  assign sb_o    = sb_q[QW-1];

endmodule

[rtl/two_body_elastic_force_unit.sv]
// Hooke's law spring between two bodies in the plane, fixed point
// Q(COORD_WIDTH-FRAC_BITS).FRAC_BITS. Takes one body pair per cycle and
// returns one force word per pair, in order, through a bit-per-stage
// square root and a bit-per-stage divider that scales the force by d/L.
// The whole pipe freezes while a finished word waits at the output
// register. A coincident pair gives zero force; in bungee mode a pair at
// or inside the rest length gives zero force. Each output field saturates
// on its own; the second body's force is the saturated negation of the
// exact first-body force. Write the config registers only while the pipe
// is empty.
module two_body_elastic_force_unit #(
  parameter int COORD_WIDTH = tbef_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = tbef_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tbef_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tbef_pkg::REG_W-1:0]     cfg_data_i,
  tbef_in_if.sink                        in_if,
  tbef_out_if.source                     out_if
);
  import tbef_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int AW  = CW;                       // |d| per axis
  localparam int SW  = 2 * CW + 1;               // dx^2 + dy^2
  localparam int LW  = CW + 1;                   // length
  localparam int EW  = (LW > REG_W) ? LW : REG_W;
  localparam int MW  = REG_W + EW;               // stiffness * |e|
  localparam int H   = (MW + 1) / 2;
  localparam int MHW = MW - H;
  localparam int NW  = MW + AW;
  localparam int QW  = MW - F;
  localparam int SBS = 2 * AW + 2;

  localparam logic [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};

  // config registers
  logic [REG_W-1:0] rest_q, stiff_q;
  logic             slack_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q  <= REST_RESET;
      stiff_q <= STIFF_RESET;
      slack_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REST:  rest_q  <= cfg_data_i;
        CFG_STIFF: stiff_q <= cfg_data_i;
        CFG_SLACK: slack_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_v_q;
  assign adv         = !out_v_q || out_if.ready;
  assign in_if.ready = adv;

  // stage 0: differences and magnitudes
  logic [CW:0]   dx, dy;
  logic [AW-1:0] ax_abs, ay_abs;
  assign dx     = {in_if.first_x[CW-1], in_if.first_x} - {in_if.second_x[CW-1], in_if.second_x};
  assign dy     = {in_if.first_y[CW-1], in_if.first_y} - {in_if.second_y[CW-1], in_if.second_y};
  assign ax_abs = dx[CW] ? AW'(-dx) : dx[AW-1:0];
  assign ay_abs = dy[CW] ? AW'(-dy) : dy[AW-1:0];

  logic          s0_v_q, s1_v_q, s2_v_q;
  logic [AW-1:0] s0_ax_q, s0_ay_q, s1_ax_q, s1_ay_q, s2_ax_q, s2_ay_q;
  logic          s0_nx_q, s0_ny_q, s1_nx_q, s1_ny_q, s2_nx_q, s2_ny_q;
  logic [2*AW-1:0] s1_sqx_q, s1_sqy_q;
  logic [SW-1:0] s2_sum_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_ax_q  <= ax_abs;
      s0_ay_q  <= ay_abs;
      s0_nx_q  <= dx[CW];
      s0_ny_q  <= dy[CW];
      s1_sqx_q <= s0_ax_q * s0_ax_q;
      s1_sqy_q <= s0_ay_q * s0_ay_q;
      s1_ax_q  <= s0_ax_q;
      s1_ay_q  <= s0_ay_q;
      s1_nx_q  <= s0_nx_q;
      s1_ny_q  <= s0_ny_q;
      s2_sum_q <= {1'b0, s1_sqx_q} + {1'b0, s1_sqy_q};
      s2_ax_q  <= s1_ax_q;
      s2_ay_q  <= s1_ay_q;
      s2_nx_q  <= s1_nx_q;
      s2_ny_q  <= s1_ny_q;
    end
  end

  // square root
  logic            sq_v;
  logic [LW-1:0]   sq_root;
  logic [SBS-1:0]  sq_sb;
  logic [AW-1:0]   sq_ax, sq_ay;
  logic            sq_nx, sq_ny;

  tbef_sqrt_pipe #(.LW(LW), .SBW(SBS)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s2_v_q),
    .rad_i   ({1'b0, s2_sum_q}),
    .sb_i    ({s2_ax_q, s2_ay_q, s2_nx_q, s2_ny_q}),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .sb_o    (sq_sb)
  );
  assign {sq_ax, sq_ay, sq_nx, sq_ny} = sq_sb;

  // stage 3: length error and special cases
  logic [EW-1:0] len_e, rest_e;
  logic          e_neg, len_zero_out;
  assign len_e        = EW'(sq_root);
  assign rest_e       = EW'(rest_q);
  assign e_neg        = len_e < rest_e;
  assign len_zero_out = (sq_root == '0) || (slack_q && (len_e <= rest_e));

  logic          s3_v_q, s4_v_q, s5_v_q, s6_v_q;
  logic [EW-1:0] s3_ae_q;
  logic [LW-1:0] s3_len_q, s4_len_q, s5_len_q, s6_len_q;
  logic [AW-1:0] s3_ax_q, s3_ay_q, s4_ax_q, s4_ay_q;
  logic [2:0]    s3_sb_q, s4_sb_q, s5_sb_q, s6_sb_q;  // zero, x neg, y neg
  logic [MW-1:0] s4_m_q;
  logic [H+AW-1:0]   s5_plx_q, s5_ply_q;
  logic [MHW+AW-1:0] s5_phx_q, s5_phy_q;
  logic [NW-F-1:0]   s6_nhx_q, s6_nhy_q;

  logic [NW-1:0] nx_full, ny_full;
  assign nx_full = NW'(s5_plx_q) + (NW'(s5_phx_q) << H);
  assign ny_full = NW'(s5_ply_q) + (NW'(s5_phy_q) << H);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_ae_q  <= e_neg ? (rest_e - len_e) : (len_e - rest_e);
      s3_len_q <= sq_root;
      s3_ax_q  <= sq_ax;
      s3_ay_q  <= sq_ay;
      s3_sb_q  <= {len_zero_out, e_neg == sq_nx, e_neg == sq_ny};
      s4_m_q   <= stiff_q * s3_ae_q;
      s4_len_q <= s3_len_q;
      s4_ax_q  <= s3_ax_q;
      s4_ay_q  <= s3_ay_q;
      s4_sb_q  <= s3_sb_q;
      s5_plx_q <= s4_m_q[H-1:0] * s4_ax_q;
      s5_phx_q <= s4_m_q[MW-1:H] * s4_ax_q;
      s5_ply_q <= s4_m_q[H-1:0] * s4_ay_q;
      s5_phy_q <= s4_m_q[MW-1:H] * s4_ay_q;
      s5_len_q <= s4_len_q;
      s5_sb_q  <= s4_sb_q;
      s6_nhx_q <= nx_full[NW-1:F];
      s6_nhy_q <= ny_full[NW-1:F];
      s6_len_q <= s5_len_q;
      s6_sb_q  <= s5_sb_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
    end else if (adv) begin
      s0_v_q <= in_if.valid;
      s1_v_q <= s0_v_q;
      s2_v_q <= s1_v_q;
      s3_v_q <= sq_v;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
    end
  end

  // divide by length; high part of the numerator is below the length
  // because |c| <= L
  logic                        dv_v;
  logic [NUM_AXES-1:0][QW-1:0] dv_q;
  logic [2:0]                  dv_sb;

  tbef_div_pipe #(.LW(LW), .QW(QW), .SBW(3)) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (s6_v_q),
    .div_i    (s6_len_q),
    .num_hi_i ({LW'(s6_nhy_q[QW+AW-1:QW]), LW'(s6_nhx_q[QW+AW-1:QW])}),
    .num_lo_i ({s6_nhy_q[QW-1:0], s6_nhx_q[QW-1:0]}),
    .sb_i     (s6_sb_q),
    .valid_o  (dv_v),
    .quot_o   (dv_q),
    .sb_o     (dv_sb)
  );

  function automatic logic [CW-1:0] sat_enc(input logic [QW-1:0] q, input logic neg);
    logic [QW-1:0] lim;
    logic [QW-1:0] mag;
    lim = neg ? (QW'(1) << (CW - 1)) : ((QW'(1) << (CW - 1)) - QW'(1));
    mag = (q > lim) ? lim : q;
    return neg ? (~mag[CW-1:0] + CW'(1)) : mag[CW-1:0];
  endfunction

  logic [CW-1:0] ffx_q, ffy_q, fsx_q, fsy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (dv_sb[2]) begin
        ffx_q <= '0;
        ffy_q <= '0;
        fsx_q <= '0;
        fsy_q <= '0;
      end else begin
        ffx_q <= sat_enc(dv_q[0], dv_sb[1]);
        ffy_q <= sat_enc(dv_q[1], dv_sb[0]);
        fsx_q <= sat_enc(dv_q[0], !dv_sb[1]);
        fsy_q <= sat_enc(dv_q[1], !dv_sb[0]);
      end
    end
  end

  assign out_if.valid          = out_v_q;
  assign out_if.force_first_x  = ffx_q;
  assign out_if.force_first_y  = ffy_q;
  assign out_if.force_second_x = fsx_q;
  assign out_if.force_second_y = fsy_q;

  // the pipe only holds back input while a finished word waits
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> out_if.valid)
    else $error("input stalled with empty output register");

  a_opposite_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.force_first_x != SMIN && out_if.force_first_x != SMAX
    |-> out_if.force_second_x == CW'(~out_if.force_first_x + CW'(1)))
    else $error("x forces are not opposite");

  a_opposite_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.force_first_y != SMIN && out_if.force_first_y != SMAX
    |-> out_if.force_second_y == CW'(~out_if.force_first_y + CW'(1)))
    else $error("y forces are not opposite");

endmodule
